FILE: hdl/salc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

	// Fixed field widths
	localparam int OP_W        = 2;
	localparam int ADDR_IN_W   = 64;
	localparam int STAMP_W     = 64;
	localparam int CNT_W       = 32;
	localparam int SB_W        = 3;
	localparam int OFF_W       = 6;
	localparam int WAYS_CFG_W  = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int SHIFT_W     = 7;

	// Stream packing
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 + 3 * CNT_W);

	// Opcodes
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_UPD,
		ST_REREAD
	} st_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic reread;
		logic look;
		logic upd;
		logic last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: hdl/salc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/salc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic [salc_pkg::OP_W-1:0] opcode,
	output logic                           s_tready,
	output salc_pkg::cmd_t                 cmd,
	input  wire salc_pkg::sts_t            sts
);

	salc_pkg::st_t st_q;
	salc_pkg::st_t st_d;
	logic          pend_q;
	logic          pend_d;

	// State and pending second access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= salc_pkg::ST_CLEAR;
			pend_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			pend_q <= pend_d;
		end
	end

	// Next state and commands
	always_comb begin
		st_d     = st_q;
		pend_d   = pend_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (st_q)
			salc_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					st_d = salc_pkg::ST_IDLE;
				end
			end
			salc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				// drop an item with the unused opcode
				if (s_tvalid && opcode != salc_pkg::OP_NONE) begin
					cmd.accept = 1'b1;
					pend_d     = (opcode == salc_pkg::OP_MODIFY);
					st_d       = salc_pkg::ST_LOOK;
				end
			end
			salc_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				st_d     = salc_pkg::ST_UPD;
			end
			salc_pkg::ST_UPD: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.upd  = 1'b1;
					cmd.last = !pend_q;
					pend_d   = 1'b0;
					st_d     = pend_q ? salc_pkg::ST_REREAD : salc_pkg::ST_IDLE;
				end
			end
			salc_pkg::ST_REREAD: begin
				cmd.reread = 1'b1;
				st_d       = salc_pkg::ST_LOOK;
			end
			default: begin
				st_d = salc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/salc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module salc_dp #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS         = 8,
	parameter int ADDR_BITS    = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire salc_pkg::cmd_t                       cmd,
	output salc_pkg::sts_t                            sts,
	input  wire logic                                 cfg_we,
	input  wire logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic [salc_pkg::ADDR_IN_W-1:0]       in_addr,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [salc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                      m_tlast
);

	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NROWS  = 1 << MAX_SET_BITS;
	localparam int WIDX   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int EW     = 1 + ADDR_BITS + salc_pkg::STAMP_W;
	localparam int RW     = WAYS * EW;
	localparam int CNT_W  = salc_pkg::CNT_W;

	// Configuration
	logic [salc_pkg::SB_W-1:0]       set_bits_q;
	logic [salc_pkg::OFF_W-1:0]      offset_bits_q;
	logic [salc_pkg::WAYS_CFG_W-1:0] ways_q;

	logic [salc_pkg::SB_W-1:0]    sb_eff;
	logic [WAYS-1:0]              en;
	logic [ADDR_BITS-1:0]         addr_m;
	logic [ADDR_BITS-1:0]         set_full;
	logic [SET_AW-1:0]            set_mask;
	logic [SET_AW-1:0]            in_set;
	logic [salc_pkg::SHIFT_W-1:0] tag_sh;
	logic [ADDR_BITS-1:0]         in_tag;

	logic [ADDR_BITS-1:0] tag_q;
	logic [SET_AW-1:0]    set_q;
	logic [SET_AW-1:0]    clr_q;

	// Set RAM ports
	logic              ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic              ram_re;
	logic [SET_AW-1:0] ram_raddr;
	logic [RW-1:0]     rd_row;

	// Row fields
	logic [WAYS-1:0]               row_vld;
	logic [ADDR_BITS-1:0]          row_tag   [WAYS];
	logic [salc_pkg::STAMP_W-1:0]  row_stamp [WAYS];
	logic [WAYS-1:0]               match_d;
	logic [WAYS-1:0]               inval_d;
	logic [WAYS-1:0]               lt_d [WAYS];
	logic [WAYS-1:0]               match_q;
	logic [WAYS-1:0]               inval_q;
	logic [WAYS-1:0]               lt_q [WAYS];

	// Update
	logic                          hit;
	logic                          have_empty;
	logic                          evict;
	logic [WIDX-1:0]               hit_way;
	logic [WIDX-1:0]               empty_way;
	logic [WIDX-1:0]               min_way;
	logic [WIDX-1:0]               victim;
	logic [WAYS-1:0]               cand;
	logic [salc_pkg::STAMP_W-1:0]  new_stamp;
	logic [RW-1:0]                 new_row;
	logic [salc_pkg::STAMP_W-1:0]  tick_q;
	logic [CNT_W-1:0]              hits_q;
	logic [CNT_W-1:0]              misses_q;
	logic [CNT_W-1:0]              evicts_q;
	logic                          out_vld_q;
	logic                          out_hit_q;
	logic                          out_ev_q;
	logic                          out_last_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			offset_bits_q <= '0;
			ways_q        <= salc_pkg::WAYS_CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				salc_pkg::REG_SET_BITS:    set_bits_q    <= cfg_wdata[salc_pkg::SB_W-1:0];
				salc_pkg::REG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				salc_pkg::REG_WAYS:        ways_q        <= cfg_wdata[salc_pkg::WAYS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp set bits, enable ways in use (way 0 always)
	always_comb begin
		sb_eff = (int'(set_bits_q) > MAX_SET_BITS) ?
			salc_pkg::SB_W'(MAX_SET_BITS) : set_bits_q;
		for (int w = 0; w < WAYS; w++) begin
			en[w] = (w == 0) || (int'(ways_q) > w);
		end
	end

	// Split the incoming address into set and tag
	always_comb begin
		addr_m   = in_addr[ADDR_BITS-1:0];
		set_full = addr_m >> offset_bits_q;
		set_mask = ~({SET_AW{1'b1}} << sb_eff);
		in_set   = set_full[SET_AW-1:0] & set_mask;
		tag_sh   = salc_pkg::SHIFT_W'(offset_bits_q) + salc_pkg::SHIFT_W'(sb_eff);
		in_tag   = addr_m >> tag_sh;
	end

	// Hold set and tag of the item at work
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tag_q <= in_tag;
			set_q <= in_set;
		end
	end

	// Clearing sweep row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + SET_AW'(1);
		end
	end

	assign sts.clr_done = (clr_q == SET_AW'(NROWS - 1));

	// Set RAM access
	always_comb begin
		ram_we    = cmd.clr_step | cmd.upd;
		ram_waddr = cmd.clr_step ? clr_q : set_q;
		ram_wdata = cmd.clr_step ? '0 : new_row;
		ram_re    = cmd.accept | cmd.reread;
		ram_raddr = cmd.accept ? in_set : set_q;
	end

	salc_ram #(
		.W     (RW),
		.DEPTH (NROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_row)
	);

	// Unpack the row, compare tags and stamps across ways
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			row_vld[w]   = rd_row[w*EW];
			row_tag[w]   = rd_row[w*EW+1 +: ADDR_BITS];
			row_stamp[w] = rd_row[w*EW+1+ADDR_BITS +: salc_pkg::STAMP_W];
			match_d[w]   = en[w] & row_vld[w] & (row_tag[w] == tag_q);
			inval_d[w]   = en[w] & ~row_vld[w];
		end
		for (int w = 0; w < WAYS; w++) begin
			for (int v = 0; v < WAYS; v++) begin
				lt_d[w][v] = (w != v) && (row_stamp[w] < row_stamp[v]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			match_q <= match_d;
			inval_q <= inval_d;
			lt_q    <= lt_d;
		end
	end

	// Pick hit way, first empty way or first oldest way
	always_comb begin
		hit        = |match_q;
		have_empty = |inval_q;
		hit_way    = '0;
		empty_way  = '0;
		min_way    = '0;
		for (int w = 0; w < WAYS; w++) begin
			cand[w] = en[w];
			for (int v = 0; v < WAYS; v++) begin
				if (v < w && en[v]) begin
					cand[w] = cand[w] & lt_q[w][v];
				end else if (v > w && en[v]) begin
					cand[w] = cand[w] & ~lt_q[v][w];
				end
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match_q[w]) begin
				hit_way = WIDX'(w);
			end
			if (inval_q[w]) begin
				empty_way = WIDX'(w);
			end
			if (cand[w]) begin
				min_way = WIDX'(w);
			end
		end
		evict     = !hit && !have_empty;
		victim    = hit ? hit_way : (have_empty ? empty_way : min_way);
		new_stamp = tick_q + salc_pkg::STAMP_W'(1);
		new_row   = rd_row;
		for (int w = 0; w < WAYS; w++) begin
			if (WIDX'(w) == victim) begin
				new_row[w*EW +: EW] = {new_stamp, tag_q, 1'b1};
			end
		end
	end

	// Tick and saturating counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (cmd.upd) begin
			tick_q <= new_stamp;
			if (hit && hits_q != '1) begin
				hits_q <= hits_q + CNT_W'(1);
			end
			if (!hit && misses_q != '1) begin
				misses_q <= misses_q + CNT_W'(1);
			end
			if (evict && evicts_q != '1) begin
				evicts_q <= evicts_q + CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.upd) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_hit_q  <= hit;
			out_ev_q   <= evict;
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_free = !out_vld_q || m_tready;
	assign m_tvalid     = out_vld_q;
	assign m_tlast      = out_last_q;
	assign m_tdata      = {{salc_pkg::OUT_PAD_W{1'b0}}, evicts_q, misses_q, hits_q,
		out_ev_q, out_hit_q};

endmodule

`default_nettype wire

FILE: hdl/set_assoc_lru_cache_tags.sv
// A taken item's set row is read, compared in LOOK and written back in UPD, which
// loads the output register, waiting while it is held; a modify then runs REREAD,
// LOOK and UPD for its second result. Items are taken only in IDLE, one at a time,
// paced by the read, compare and write-back of one set row in the set RAM. Reset:
// arst_n clears control, configuration and counts; a sweep of all 2^MAX_SET_BITS
// rows (64 by default) then zeroes the set RAM with s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_tags #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS         = 8,
	parameter int ADDR_BITS    = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// opcode [1:0], address [65:2], zero [71:66]
	input  wire logic [salc_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// hit [0], evicted [1], hit_count [33:2], miss_count [65:34],
	// evict_count [97:66], zero [103:98]
	output logic      [salc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                      m_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic                                 cfg_we,
	input  wire logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	salc_pkg::cmd_t cmd;
	salc_pkg::sts_t sts;

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tdata[salc_pkg::OP_W-1:0]),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	salc_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.WAYS         (WAYS),
		.ADDR_BITS    (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_addr   (s_tdata[salc_pkg::OP_W +: salc_pkg::ADDR_IN_W]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

FILE: hdl/salc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module salc_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [salc_pkg::OP_W-1:0]        s_op,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [salc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic                             m_tlast
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// One item at a time: no accept right after an accepted access
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_op != salc_pkg::OP_NONE |=> !s_tready)
		else $error("item taken while the previous one is at work");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("hit reported with eviction");

	// Counts cover the result shown
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[33:2] != 32'd0)
		else $error("hit with zero hit count");

	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[97:66] != 32'd0 && m_tdata[65:34] != 32'd0)
		else $error("eviction with zero eviction or miss count");

endmodule

bind set_assoc_lru_cache_tags salc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_op     (s_tdata[salc_pkg::OP_W-1:0]),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import salc_pkg::*;

	localparam int MAX_SB      = 6;
	localparam int NWAYS       = 8;
	localparam int NLINES      = (1 << MAX_SB) * NWAYS;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 165;

	// One expected access outcome, as carried by an output item
	typedef struct {
		logic             hit;
		logic             evicted;
		logic             last;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evicts;
	} access_result_t;

	// Shadow tag store: predicts each access and checks the output items
	class cache_tag_tracker;
		logic               line_ok  [NLINES];
		logic [63:0]        line_tag [NLINES];
		logic [STAMP_W-1:0] line_age [NLINES];
		logic [STAMP_W-1:0] tick;
		logic [CNT_W-1:0]   hits;
		logic [CNT_W-1:0]   misses;
		logic [CNT_W-1:0]   evicts;
		logic [SB_W-1:0]       set_bits;
		logic [OFF_W-1:0]      offset_bits;
		logic [WAYS_CFG_W-1:0] ways_in_use;
		access_result_t     due_results [$];
		int                 errors;

		function new();
			for (int i = 0; i < NLINES; i++) begin
				line_ok[i]  = 1'b0;
				line_tag[i] = '0;
				line_age[i] = '0;
			end
			tick        = '0;
			hits        = '0;
			misses      = '0;
			evicts      = '0;
			set_bits    = '0;
			offset_bits = '0;
			ways_in_use = 4'd1;
			errors      = 0;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + CNT_W'(1);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_SET_BITS:    set_bits    = v[SB_W-1:0];
				REG_OFFSET_BITS: offset_bits = v[OFF_W-1:0];
				REG_WAYS:        ways_in_use = v[WAYS_CFG_W-1:0];
				default: ;
			endcase
		endfunction

		// One lookup of the set; fills or evicts on a miss
		function void lookup_line(logic [63:0] a, logic is_last);
			int sb_eff, ways, base, victim, empty;
			logic [63:0] set_mask, set_idx, tag;
			logic [STAMP_W-1:0] oldest;
			access_result_t r;
			sb_eff = (set_bits > MAX_SB) ? MAX_SB : int'(set_bits);
			ways   = (ways_in_use == 0) ? 1 : int'(ways_in_use);
			if (ways > NWAYS)
				ways = NWAYS;
			set_mask  = (64'd1 << sb_eff) - 64'd1;
			set_idx   = (a >> offset_bits) & set_mask;
			tag       = a >> (offset_bits + sb_eff);
			base      = int'(set_idx) * NWAYS;
			empty     = -1;
			victim    = 0;
			r.hit     = 1'b0;
			r.evicted = 1'b0;
			for (int w = 0; w < ways; w++) begin
				if (line_ok[base + w] && line_tag[base + w] == tag) begin
					r.hit = 1'b1;
					hits  = bump(hits);
					tick  = tick + STAMP_W'(1);
					line_age[base + w] = tick;
					break;
				end
			end
			if (!r.hit) begin
				oldest = line_age[base];
				misses = bump(misses);
				for (int w = 0; w < ways; w++) begin
					if (!line_ok[base + w] && empty < 0)
						empty = w;
					if (line_age[base + w] < oldest) begin
						oldest = line_age[base + w];
						victim = w;
					end
				end
				if (empty >= 0) begin
					victim = empty;
				end else begin
					r.evicted = 1'b1;
					evicts    = bump(evicts);
				end
				tick = tick + STAMP_W'(1);
				line_ok[base + victim]  = 1'b1;
				line_tag[base + victim] = tag;
				line_age[base + victim] = tick;
			end
			r.last   = is_last;
			r.hits   = hits;
			r.misses = misses;
			r.evicts = evicts;
			due_results.push_back(r);
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [63:0] addr);
			case (op)
				OP_LOAD, OP_STORE: lookup_line(addr, 1'b1);
				OP_MODIFY: begin
					lookup_line(addr, 1'b0);
					lookup_line(addr, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d, logic l);
			access_result_t e;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected item, expected none actual %0h", $time, d);
				errors++;
				return;
			end
			e = due_results.pop_front();
			compare("hit", CNT_W'(e.hit), CNT_W'(d[0]));
			compare("evicted", CNT_W'(e.evicted), CNT_W'(d[1]));
			compare("last", CNT_W'(e.last), CNT_W'(l));
			compare("hit_count", e.hits, d[2 +: CNT_W]);
			compare("miss_count", e.misses, d[2 + CNT_W +: CNT_W]);
			compare("evict_count", e.evicts, d[2 + 2 * CNT_W +: CNT_W]);
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tlast;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b1;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	cache_tag_tracker tracker;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold  = 0;
	int rx_stall;
	logic [OP_W-1:0] op_pick [3] = '{OP_LOAD, OP_STORE, OP_MODIFY};

	always #6 clk = ~clk;

	set_assoc_lru_cache_tags uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Take output items, then hold tready low for a drawn number of cycles
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			if (rx_hold == 1)
				m_tready <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			tracker.check_result(m_tdata, m_tlast);
			rx_stall = rx_quiet ? 0 : int'($urandom_range(0, 17));
			if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_hold  <= rx_stall;
			end
		end
	end

	// Offer one access after a drawn gap and wait for it to be taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [63:0] addr);
		int gap;
		gap = tx_quiet ? 0 : int'($urandom_range(0, 17));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {{(IN_TDATA_W - OP_W - 64){1'b0}}, addr, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(op, addr);
	endtask

	// Stop sending, wait for every outstanding item, then let the pipe empty
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] sbv,
			input logic [CFG_DATA_W-1:0] offv, input logic [CFG_DATA_W-1:0] waysv);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SET_BITS;
		cfg_wdata <= sbv;
		@(posedge clk);
		tracker.set_reg(REG_SET_BITS, sbv);
		cfg_index <= REG_OFFSET_BITS;
		cfg_wdata <= offv;
		@(posedge clk);
		tracker.set_reg(REG_OFFSET_BITS, offv);
		cfg_index <= REG_WAYS;
		cfg_wdata <= waysv;
		@(posedge clk);
		tracker.set_reg(REG_WAYS, waysv);
		cfg_we <= 1'b0;
	endtask

	// Mostly addresses that crowd a few sets with a few tags, so hits and
	// evictions both occur; the rest are fully random
	function automatic logic [63:0] pick_addr(logic [63:0] tag_base);
		int sb_eff;
		logic [63:0] a, low_mask, set_sel, tag_sel;
		sb_eff = (tracker.set_bits > MAX_SB) ? MAX_SB : int'(tracker.set_bits);
		if ($urandom_range(0, 9) < 2)
			return {$urandom, $urandom};
		set_sel  = 64'($urandom_range(0, 3));
		tag_sel  = 64'($urandom_range(0, 11));
		low_mask = (64'd1 << tracker.offset_bits) - 64'd1;
		a = {$urandom, $urandom} & low_mask;
		a = a | ((set_sel & ((64'd1 << sb_eff) - 64'd1)) << tracker.offset_bits);
		a = a | ((tag_base ^ tag_sel) << (tracker.offset_bits + sb_eff));
		return a;
	endfunction

	initial begin
		logic [63:0] tag_base;
		int n;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one set, one way, whole address as tag
		send_item(OP_LOAD, 64'd0);
		send_item(OP_LOAD, 64'd0);
		send_item(OP_STORE, '1);
		send_item(OP_MODIFY, '1);
		send_item(OP_MODIFY, 64'h8000_0000_0000_0000);
		send_item(OP_NONE, '1);
		send_item(OP_LOAD, 64'h5555_5555_5555_5555);
		send_item(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_NONE, 64'd0);
		send_item(OP_LOAD, 64'd0);
		drain_results();

		// Fill all eight ways, refresh one, then force least-recent evictions
		write_regs(6'd0, 6'd0, 6'd8);
		for (int t = 1; t <= 8; t++)
			send_item(OP_LOAD, 64'(t));
		send_item(OP_LOAD, 64'd1);
		send_item(OP_STORE, 64'd9);
		send_item(OP_LOAD, 64'd2);
		send_item(OP_MODIFY, 64'd2);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_regs(6'd7, 6'd63, 6'd0);
				1: write_regs(6'd6, 6'd0, 6'd8);
				2: write_regs(6'd2, 6'd5, 6'd15);
				3: write_regs(6'd0, 6'd60, 6'd3);
				4: write_regs(6'd3, 6'd6, 6'd2);
				5: write_regs(6'd3, 6'd6, 6'd8);
				6: write_regs(6'd63, 6'd32, 6'd63);
				default: write_regs(CFG_DATA_W'($urandom_range(0, 63)),
					CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 63) : $urandom_range(0, 12)),
					CFG_DATA_W'($urandom_range(0, 63)));
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			tag_base = {$urandom, $urandom};
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(OP_NONE, {$urandom, $urandom});
				end else begin
					send_item(op_pick[$urandom_range(0, 2)], pick_addr(tag_base));
					n++;
				end
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
			drain_results();
		end

		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/salc_ctrl.sv
hdl/salc_dp.sv
hdl/set_assoc_lru_cache_tags.sv
hdl/salc_chk.sv
sim/testbench.sv
